[sv/bgc_pkg.sv]
// ----------------------------------------------------------------------------
// bgc_pkg: shared types and constants for the button gesture classifier
// Field widths, status and op codes, lane request/response structs.
// ----------------------------------------------------------------------------
package bgc_pkg;

    localparam int NUM_BUTTONS = 8;
    localparam int LEVELS_W    = 8;
    localparam int IDX_W       = 3;
    localparam int TIME_W      = 32;
    localparam int CFG_W       = 16;
    localparam int OP_W        = 2;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 16;

    localparam logic [CFG_W-1:0] WINDOW_RESET = 16'd200;
    localparam logic [CFG_W-1:0] LONG_RESET   = 16'd1000;

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE = 2'd0,
        OP_READ   = 2'd1,
        OP_ACK    = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_PLAIN   = 3'd1,
        ST_LONG    = 3'd2,
        ST_DOUBLE  = 3'd3,
        ST_WAITING = 3'd4
    } t_status;

    typedef enum logic {
        CFG_WINDOW = 1'b0,
        CFG_LONG   = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic              sample;
        logic [TIME_W-1:0] now;
        logic [CFG_W-1:0]  window_ms;
        logic [CFG_W-1:0]  long_ms;
    } t_lane_req;

    typedef struct packed {
        t_status status;
        logic    hit;
    } t_lane_rsp;

    typedef struct packed {
        t_status             status;
        logic [LEVELS_W-1:0] event_mask;
    } t_result;

endpackage

[sv/button_gesture_classifier.sv]
// ----------------------------------------------------------------------------
// button_gesture_classifier: click, long hold and double press detector
// One result per request, registered on m_axis via the output skid buffer.
// Throughput: one request per cycle while s_axis_tready is high.
// A two-entry output buffer keeps s_axis_tready high while one result stalls.
// Reset (synchronous, active low) idles all buttons and restores the window
// (200 ms) and long hold (1000 ms) settings.
// ----------------------------------------------------------------------------
module button_gesture_classifier (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic                                i_cfg_index,
    input  logic [bgc_pkg::CFG_W-1:0]           i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // button_index[2:0], levels[10:3], now_ms[42:11], zero fill
    input  logic [bgc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // op[1:0]
    input  logic [bgc_pkg::OP_W-1:0]            s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // status[2:0], event_mask[10:3], zero fill
    output logic [bgc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    logic [bgc_pkg::CFG_W-1:0]      r_window_ms;
    logic [bgc_pkg::CFG_W-1:0]      r_long_ms;

    logic                           accept;
    bgc_pkg::t_op                   op;
    logic [bgc_pkg::IDX_W-1:0]      btn_index;
    logic [bgc_pkg::LEVELS_W-1:0]   levels;
    bgc_pkg::t_lane_req             lane_req;
    bgc_pkg::t_lane_rsp             lane_rsp [bgc_pkg::NUM_BUTTONS];
    bgc_pkg::t_result               result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_ms <= bgc_pkg::WINDOW_RESET;
            r_long_ms   <= bgc_pkg::LONG_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (bgc_pkg::t_cfg_index'(i_cfg_index))
                bgc_pkg::CFG_WINDOW: r_window_ms <= i_cfg_wdata;
                bgc_pkg::CFG_LONG:   r_long_ms   <= i_cfg_wdata;
                default:             ;
            endcase
        end
    end

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign op        = bgc_pkg::t_op'(s_axis_tuser);
    assign btn_index = s_axis_tdata[2:0];
    assign levels    = s_axis_tdata[10:3];

    assign lane_req.sample    = accept && (op == bgc_pkg::OP_SAMPLE);
    assign lane_req.now       = s_axis_tdata[42:11];
    assign lane_req.window_ms = r_window_ms;
    assign lane_req.long_ms   = r_long_ms;

    for (genvar g = 0; g < bgc_pkg::NUM_BUTTONS; g++) begin : g_lane
        logic level;
        logic ack;
        if (g < bgc_pkg::LEVELS_W) begin : g_lvl
            assign level = levels[g];
        end else begin : g_nolvl
            assign level = 1'b0;
        end
        assign ack = accept && (op == bgc_pkg::OP_ACK) && (32'(btn_index) == g);

        bgc_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_req   (lane_req),
            .i_level (level),
            .i_ack   (ack),
            .o_rsp   (lane_rsp[g])
        );
    end

    bgc_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_op        (op),
        .i_index     (btn_index),
        .i_rsp       (lane_rsp),
        .i_out_ready (m_axis_tready),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_result    (result)
    );

    assign m_axis_tdata = {5'd0, result.event_mask, result.status};

endmodule

[sv/bgc_lane.sv]
// ----------------------------------------------------------------------------
// bgc_lane: per-button gesture tracker
// Holds level, press/release times and status of one button.
// ----------------------------------------------------------------------------
module bgc_lane (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bgc_pkg::t_lane_req  i_req,
    input  logic                i_level,
    input  logic                i_ack,
    output bgc_pkg::t_lane_rsp  o_rsp
);

    logic                         r_held,    n_held;
    bgc_pkg::t_status             r_status,  n_status;
    logic [bgc_pkg::TIME_W-1:0]   r_press,   n_press;
    logic [bgc_pkg::TIME_W-1:0]   r_release, n_release;

    logic                         expired;
    logic                         long_hit;
    logic                         hit;
    bgc_pkg::t_status             st_live;

    always_comb begin
        expired  = (r_status == bgc_pkg::ST_WAITING) &&
                   ((i_req.now - r_release) >= bgc_pkg::TIME_W'(i_req.window_ms));
        long_hit = (i_req.now - r_press) >= bgc_pkg::TIME_W'(i_req.long_ms);
        st_live  = expired ? bgc_pkg::ST_IDLE : r_status;
    end

    always_comb begin
        n_held    = r_held;
        n_status  = r_status;
        n_press   = r_press;
        n_release = r_release;
        hit       = 1'b0;
        if (i_req.sample) begin
            n_status = st_live;
            if (i_level) begin
                if (!r_held) begin
                    n_press = i_req.now;
                end
                n_held = 1'b1;
            end else if (r_held) begin
                n_release = i_req.now;
                n_held    = 1'b0;
                hit       = 1'b1;
                priority if (st_live == bgc_pkg::ST_WAITING) begin
                    n_status = bgc_pkg::ST_DOUBLE;
                end else if (long_hit) begin
                    n_status = bgc_pkg::ST_LONG;
                end else begin
                    n_status = bgc_pkg::ST_PLAIN;
                end
            end
        end else if (i_ack) begin
            n_status = (r_status == bgc_pkg::ST_PLAIN) ? bgc_pkg::ST_WAITING
                                                       : bgc_pkg::ST_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held   <= 1'b0;
            r_status <= bgc_pkg::ST_IDLE;
        end else begin
            r_held   <= n_held;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_press   <= n_press;
        r_release <= n_release;
    end

    assign o_rsp.status = r_status;
    assign o_rsp.hit    = hit;

endmodule

[sv/bgc_merge.sv]
// ----------------------------------------------------------------------------
// bgc_merge: combine lane responses into one result
// Selects the addressed status, gathers the event mask, output skid buffer.
// ----------------------------------------------------------------------------
module bgc_merge (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  bgc_pkg::t_op                  i_op,
    input  logic [bgc_pkg::IDX_W-1:0]     i_index,
    input  bgc_pkg::t_lane_rsp            i_rsp [bgc_pkg::NUM_BUTTONS],
    input  logic                          i_out_ready,
    output logic                          o_in_ready,
    output logic                          o_out_valid,
    output bgc_pkg::t_result              o_result
);

    bgc_pkg::t_status                status_sel;
    logic [bgc_pkg::LEVELS_W-1:0]    hit_mask;
    bgc_pkg::t_result                result;

    logic                            r_out_valid,  n_out_valid;
    logic                            r_skid_valid, n_skid_valid;
    bgc_pkg::t_result                r_out,        n_out;
    bgc_pkg::t_result                r_skid,       n_skid;

    always_comb begin
        status_sel = bgc_pkg::ST_IDLE;
        for (int i = 0; i < bgc_pkg::NUM_BUTTONS; i++) begin
            if (32'(i_index) == i) begin
                status_sel = i_rsp[i].status;
            end
        end
    end

    for (genvar g = 0; g < bgc_pkg::LEVELS_W; g++) begin : g_mask
        if (g < bgc_pkg::NUM_BUTTONS) begin : g_used
            assign hit_mask[g] = i_rsp[g].hit;
        end else begin : g_none
            assign hit_mask[g] = 1'b0;
        end
    end

    always_comb begin
        result.status     = bgc_pkg::ST_IDLE;
        result.event_mask = '0;
        unique case (i_op)
            bgc_pkg::OP_SAMPLE: result.event_mask = hit_mask;
            bgc_pkg::OP_READ:   result.status     = status_sel;
            bgc_pkg::OP_ACK:    ;
            default:            ;
        endcase
    end

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (r_skid_valid && !n_out_valid) begin
            n_out        = r_skid;
            n_out_valid  = 1'b1;
            n_skid_valid = 1'b0;
        end else if (i_accept) begin
            if (n_out_valid) begin
                n_skid       = result;
                n_skid_valid = 1'b1;
            end else begin
                n_out       = result;
                n_out_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_in_ready  = !r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

[sv/bgc_checker.sv]
// ----------------------------------------------------------------------------
// bgc_checker: port-level checks for the button gesture classifier
// Watches the result stream and reset behavior.
// ----------------------------------------------------------------------------
module bgc_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [bgc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= 3'd4)
        else $error("status code out of range");

    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:0] == 3'd0) || (m_axis_tdata[10:3] == 8'd0))
        else $error("status and event mask both set");

    a_fill_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:11] == 5'd0)
        else $error("fill bits not zero");

endmodule

bind button_gesture_classifier bgc_checker u_bgc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
